// ===== src/mtra_pkg.sv =====
// shared types and constants of the memory type region allocator
// no dependencies; used by the datapath, the controller and the top level
`timescale 1ns / 1ps

package mtra_pkg;

  localparam int unsigned ADDR_BITS   = 36;
  localparam int unsigned PAGE_BITS   = 12;
  localparam int unsigned PAGE_W      = ADDR_BITS - PAGE_BITS;
  localparam int unsigned SIZE_W      = ADDR_BITS + 1;
  localparam int unsigned KIND_W      = 8;
  localparam int unsigned TYPE_W      = 3;
  localparam int unsigned STATUS_W    = 4;
  localparam int unsigned SLOT_OUT_W  = 3;
  localparam int unsigned SLOTS_W     = 4;
  localparam int unsigned PAB_W       = 6;
  localparam int unsigned CFG_W       = 6;
  localparam int unsigned CFG_IDX_W   = 2;
  localparam int unsigned HI_PAGE_BIT = 32 - PAGE_BITS;
  localparam int unsigned ENTRY_W     = 2 * PAGE_W + KIND_W;

  localparam logic        MODE_READ  = 1'b1;
  localparam logic [2:0]  MT_WC      = 3'd1;
  localparam logic [2:0]  MT_RSV2    = 3'd2;
  localparam logic [2:0]  MT_RSV3    = 3'd3;
  localparam logic [2:0]  MT_UNKNOWN = 3'd7;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK             = 4'd0,
    ST_UNSUPPORTED    = 4'd1,
    ST_MISALIGNED     = 4'd2,
    ST_OVER_RANGE     = 4'd3,
    ST_NOT_POW2       = 4'd4,
    ST_UNALIGNED_BASE = 4'd5,
    ST_BAD_TYPE       = 4'd6,
    ST_RESERVED_TYPE  = 4'd7,
    ST_WC_UNSUPPORTED = 4'd8,
    ST_NO_SLOT        = 4'd9,
    ST_BAD_INDEX      = 4'd10
  } status_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FEATURE = 2'd0,
    CFG_WC      = 2'd1,
    CFG_SLOTS   = 2'd2,
    CFG_PAB     = 2'd3
  } cfg_idx_e;

  typedef struct packed {
    logic capture;
    logic check;
    logic idx_rd;
    logic scan_start;
    logic scan_rd;
    logic scan_cmp;
    logic pick;
    logic out_load;
  } dp_cmd_t;

  typedef struct packed {
    logic chk_fail;
    logic is_read;
    logic scan_empty;
    logic scan_last;
    logic out_free;
  } dp_stat_t;

endpackage

// ===== src/mtra_ram.sv =====
// generic simple dual-port ram with registered read data
// no dependencies
`timescale 1ns / 1ps

module mtra_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 8
) (
  input  logic                                    clk_i,
  input  logic                                    we_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                        wdata_i,
  input  logic                                    re_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                        rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== src/mtra_datapath.sv =====
// datapath: config registers, request checks, slot scan, slot table and result register
// depends on mtra_pkg and mtra_ram
`timescale 1ns / 1ps

module mtra_datapath #(
  parameter int unsigned MAX_SLOTS = 8
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  mtra_pkg::dp_cmd_t                 cmd_i,
  output mtra_pkg::dp_stat_t                stat_o,
  input  logic                              cfg_we_i,
  input  logic [mtra_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [mtra_pkg::CFG_W-1:0]        cfg_data_i,
  input  logic                              mode_i,
  input  logic [mtra_pkg::ADDR_BITS-1:0]    region_base_i,
  input  logic [mtra_pkg::SIZE_W-1:0]       region_size_i,
  input  logic [mtra_pkg::TYPE_W-1:0]       memory_type_i,
  input  logic [mtra_pkg::SLOT_OUT_W-1:0]   slot_index_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic [mtra_pkg::STATUS_W-1:0]     status_o,
  output logic [mtra_pkg::SLOT_OUT_W-1:0]   chosen_slot_o,
  output logic [mtra_pkg::ADDR_BITS-1:0]    entry_base_o,
  output logic [mtra_pkg::SIZE_W-1:0]       entry_size_o,
  output logic [mtra_pkg::KIND_W-1:0]       entry_type_o,
  output logic                              entry_valid_o
);
  import mtra_pkg::*;

  localparam int unsigned IW    = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
  localparam int unsigned CNT_W = $clog2(MAX_SLOTS + 1);
  localparam int unsigned NW    = (CNT_W > SLOTS_W) ? CNT_W : SLOTS_W;

  function automatic logic [SIZE_W-1:0] dec_size(input logic [ADDR_BITS-1:0] pm,
                                                 input logic [PAGE_W-1:0]    mp);
    logic [ADDR_BITS-1:0] m;
    m = {mp, {PAGE_BITS{1'b0}}};
    return {1'b0, pm ^ m} + SIZE_W'(1);
  endfunction

  // configuration
  logic              feature_q;
  logic              wc_q;
  logic [SLOTS_W-1:0] slots_q;
  logic [PAB_W-1:0]  pab_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      feature_q <= 1'b1;
      wc_q      <= 1'b1;
      slots_q   <= SLOTS_W'(8);
      pab_q     <= PAB_W'(36);
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_FEATURE: feature_q <= cfg_data_i[0];
        CFG_WC:      wc_q      <= cfg_data_i[0];
        CFG_SLOTS:   slots_q   <= cfg_data_i[SLOTS_W-1:0];
        CFG_PAB:     pab_q     <= cfg_data_i[PAB_W-1:0];
        default:     ;
      endcase
    end
  end

  // captured request
  logic                  mode_q;
  logic [ADDR_BITS-1:0]  base_q;
  logic [SIZE_W-1:0]     size_q;
  logic [TYPE_W-1:0]     type_q;
  logic [SLOT_OUT_W-1:0] idx_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      mode_q <= mode_i;
      base_q <= region_base_i;
      size_q <= region_size_i;
      type_q <= memory_type_i;
      idx_q  <= slot_index_i;
    end
  end

  // derived values
  logic [ADDR_BITS-1:0] pm;
  logic [NW-1:0]        slots_ext;
  logic [NW-1:0]        n_w;
  logic [NW-1:0]        idx_ext;
  logic [IW-1:0]        idx_addr;
  logic [SIZE_W:0]      sum_w;
  logic [SIZE_W-1:0]    sm1;
  logic [ADDR_BITS-1:0] mask_new;
  status_e              chk;

  always_comb begin
    for (int k = 0; k < ADDR_BITS; k++) begin
      pm[k] = (pab_q > PAB_W'(k));
    end
  end

  assign slots_ext = NW'(slots_q);
  assign n_w       = (slots_ext > NW'(MAX_SLOTS)) ? NW'(MAX_SLOTS) : slots_ext;
  assign idx_ext   = NW'(idx_q);
  assign idx_addr  = idx_ext[IW-1:0];
  assign sum_w     = {2'b00, base_q} + {1'b0, size_q};
  assign sm1       = size_q - SIZE_W'(1);
  assign mask_new  = pm & ~sm1[ADDR_BITS-1:0];

  // request checks in priority order
  always_comb begin
    chk = ST_OK;
    if (!feature_q) begin
      chk = ST_UNSUPPORTED;
    end else if (mode_q == MODE_READ) begin
      if (idx_ext >= n_w) begin
        chk = ST_BAD_INDEX;
      end
    end else if (base_q[PAGE_BITS-1:0] != '0 || size_q[PAGE_BITS-1:0] != '0 ||
                 size_q == '0) begin
      chk = ST_MISALIGNED;
    end else if (sum_w[SIZE_W:ADDR_BITS] != '0) begin
      chk = ST_OVER_RANGE;
    end else if ((size_q & sm1) != '0) begin
      chk = ST_NOT_POW2;
    end else if ((base_q & sm1[ADDR_BITS-1:0]) != '0) begin
      chk = ST_UNALIGNED_BASE;
    end else if (type_q == MT_UNKNOWN) begin
      chk = ST_BAD_TYPE;
    end else if (type_q == MT_RSV2 || type_q == MT_RSV3) begin
      chk = ST_RESERVED_TYPE;
    end else if (type_q == MT_WC && !wc_q) begin
      chk = ST_WC_UNSUPPORTED;
    end
  end

  // slot table
  logic [MAX_SLOTS-1:0] live_q;
  logic [IW-1:0]        cnt_q;
  logic [ENTRY_W-1:0]   rdata;
  logic [PAGE_W-1:0]    rd_page;
  logic [KIND_W-1:0]    rd_kind;
  logic [PAGE_W-1:0]    rd_mask;
  logic                 ram_we;
  logic                 ram_re;
  logic [IW-1:0]        rd_addr;
  logic [ENTRY_W-1:0]   wdata;
  logic [PAGE_W-1:0]    mask_new_q;
  status_e              res_q;
  logic [IW-1:0]        slot_q;

  logic                 m_found_q, f_found_q, h_found_q;
  logic [IW-1:0]        m_idx_q, f_idx_q, h_idx_q;
  logic                 found;
  logic [IW-1:0]        pick_idx;
  logic                 cur_live;
  logic                 hit_match;
  logic                 hit_high;

  assign found    = m_found_q | f_found_q | h_found_q;
  assign pick_idx = m_found_q ? m_idx_q : (f_found_q ? f_idx_q : h_idx_q);
  assign ram_we   = cmd_i.pick & found;
  assign ram_re   = cmd_i.idx_rd | cmd_i.scan_rd;
  assign rd_addr  = cmd_i.idx_rd ? idx_addr : cnt_q;
  assign wdata    = {base_q[ADDR_BITS-1:PAGE_BITS], KIND_W'(type_q), mask_new_q};

  mtra_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (MAX_SLOTS)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (pick_idx),
    .wdata_i (wdata),
    .re_i    (ram_re),
    .raddr_i (rd_addr),
    .rdata_o (rdata)
  );

  assign rd_page   = rdata[ENTRY_W-1 -: PAGE_W];
  assign rd_kind   = rdata[PAGE_W +: KIND_W];
  assign rd_mask   = rdata[PAGE_W-1:0];
  assign cur_live  = live_q[cnt_q];
  assign hit_match = cur_live && rd_page == base_q[ADDR_BITS-1:PAGE_BITS] &&
                     dec_size(pm, rd_mask) == size_q;
  assign hit_high  = cur_live && rd_page[PAGE_W-1:HI_PAGE_BIT] != '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      live_q    <= '0;
      cnt_q     <= '0;
      m_found_q <= 1'b0;
      f_found_q <= 1'b0;
      h_found_q <= 1'b0;
      res_q     <= ST_OK;
    end else begin
      if (cmd_i.check) begin
        res_q <= chk;
      end
      if (cmd_i.scan_start) begin
        cnt_q     <= '0;
        m_found_q <= 1'b0;
        f_found_q <= 1'b0;
        h_found_q <= 1'b0;
      end
      if (cmd_i.scan_cmp) begin
        cnt_q <= cnt_q + IW'(1);
        if (hit_match && !m_found_q) begin
          m_found_q <= 1'b1;
        end
        if (!cur_live && !f_found_q) begin
          f_found_q <= 1'b1;
        end
        if (hit_high && !h_found_q) begin
          h_found_q <= 1'b1;
        end
      end
      if (cmd_i.pick) begin
        if (found) begin
          live_q[pick_idx] <= 1'b1;
        end else begin
          res_q <= ST_NO_SLOT;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.check) begin
      mask_new_q <= mask_new[ADDR_BITS-1:PAGE_BITS];
    end
    if (cmd_i.scan_cmp) begin
      if (hit_match && !m_found_q) begin
        m_idx_q <= cnt_q;
      end
      if (!cur_live && !f_found_q) begin
        f_idx_q <= cnt_q;
      end
      if (hit_high && !h_found_q) begin
        h_idx_q <= cnt_q;
      end
    end
    if (cmd_i.pick) begin
      slot_q <= pick_idx;
    end
  end

  // result register
  logic                  out_valid_q;
  status_e               out_status_q;
  logic [SLOT_OUT_W-1:0] out_slot_q;
  logic [ADDR_BITS-1:0]  out_base_q;
  logic [SIZE_W-1:0]     out_size_q;
  logic [KIND_W-1:0]     out_kind_q;
  logic                  out_live_q;
  logic                  out_free;
  logic                  rd_live;
  logic [NW-1:0]         slot_ext;
  logic [SLOT_OUT_W-1:0] res_slot;
  logic [ADDR_BITS-1:0]  res_base;
  logic [SIZE_W-1:0]     res_size;
  logic [KIND_W-1:0]     res_kind;
  logic                  res_live;

  assign out_free = !out_valid_q || out_ready_i;
  assign rd_live  = live_q[idx_addr];
  assign slot_ext = NW'(slot_q);

  always_comb begin
    res_slot = '0;
    res_base = '0;
    res_size = '0;
    res_kind = '0;
    res_live = 1'b0;
    if (res_q != ST_OK) begin
      if (res_q == ST_BAD_INDEX) begin
        res_slot = idx_q;
      end
    end else if (mode_q == MODE_READ) begin
      res_slot = idx_q;
      res_live = rd_live;
      res_base = rd_live ? {rd_page, {PAGE_BITS{1'b0}}} : '0;
      res_size = dec_size(pm, rd_live ? rd_mask : '0);
      res_kind = rd_live ? rd_kind : '0;
    end else begin
      res_slot = slot_ext[SLOT_OUT_W-1:0];
      res_live = 1'b1;
      res_base = {base_q[ADDR_BITS-1:PAGE_BITS], {PAGE_BITS{1'b0}}};
      res_size = dec_size(pm, mask_new_q);
      res_kind = KIND_W'(type_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_status_q <= res_q;
      out_slot_q   <= res_slot;
      out_base_q   <= res_base;
      out_size_q   <= res_size;
      out_kind_q   <= res_kind;
      out_live_q   <= res_live;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign status_o      = out_status_q;
  assign chosen_slot_o = out_slot_q;
  assign entry_base_o  = out_base_q;
  assign entry_size_o  = out_size_q;
  assign entry_type_o  = out_kind_q;
  assign entry_valid_o = out_live_q;

  assign stat_o.chk_fail   = (res_q != ST_OK);
  assign stat_o.is_read    = (mode_q == MODE_READ);
  assign stat_o.scan_empty = (n_w == '0);
  assign stat_o.scan_last  = ((NW'(cnt_q) + NW'(1)) == n_w);
  assign stat_o.out_free   = out_free;

  // a slot once live stays live
  a_live_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    1'b1 |=> ((live_q & $past(live_q)) == $past(live_q)))
    else $error("live slot was cleared");

  // writes only land in implemented slots
  a_write_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |-> (NW'(pick_idx) < n_w))
    else $error("slot write beyond implemented slots");

  // a result is never loaded over one still waiting
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.out_load |-> out_free)
    else $error("result register overwritten");

  // a successful program result reports a live slot
  a_prog_live: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.out_load && res_q == ST_OK && mode_q != MODE_READ) |=> entry_valid_o)
    else $error("programmed slot not reported valid");

endmodule

// ===== src/mtra_ctrl.sv =====
// controller state machine sequencing check, slot scan, write and result transfer
// depends on mtra_pkg
`timescale 1ns / 1ps

module mtra_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  mtra_pkg::dp_stat_t stat_i,
  output mtra_pkg::dp_cmd_t  cmd_o
);
  import mtra_pkg::*;

  typedef enum logic [6:0] {
    S_IDLE     = 7'b0000001,
    S_CHECK    = 7'b0000010,
    S_ROUTE    = 7'b0000100,
    S_SCAN_RD  = 7'b0001000,
    S_SCAN_CMP = 7'b0010000,
    S_PICK     = 7'b0100000,
    S_OUT      = 7'b1000000
  } state_e;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = S_CHECK;
        end
      end
      S_CHECK: begin
        cmd_o.check = 1'b1;
        state_d     = S_ROUTE;
      end
      S_ROUTE: begin
        if (stat_i.chk_fail) begin
          state_d = S_OUT;
        end else if (stat_i.is_read) begin
          cmd_o.idx_rd = 1'b1;
          state_d      = S_OUT;
        end else begin
          cmd_o.scan_start = 1'b1;
          state_d          = stat_i.scan_empty ? S_PICK : S_SCAN_RD;
        end
      end
      S_SCAN_RD: begin
        cmd_o.scan_rd = 1'b1;
        state_d       = S_SCAN_CMP;
      end
      S_SCAN_CMP: begin
        cmd_o.scan_cmp = 1'b1;
        state_d        = stat_i.scan_last ? S_PICK : S_SCAN_RD;
      end
      S_PICK: begin
        cmd_o.pick = 1'b1;
        state_d    = S_OUT;
      end
      S_OUT: begin
        if (stat_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

endmodule

// ===== src/memory_type_region_allocator.sv =====
// Variable memory-type region table.
// Input channel (in_valid_i/in_ready_o) carries one request: mode 0 programs a
// region given by base, size and type, mode 1 reads back the slot slot_index_i.
// Output channel (out_valid_o/out_ready_i) returns exactly one result per request:
// a status code, the slot used and the decoded slot contents.
// Config port: cfg_we_i writes cfg_data_i into register cfg_idx_i
// (0 feature present, 1 write-combining allowed, 2 slots in use, 3 phys bits);
// write only while no request is in flight.
// Flow: a failed request or a read goes from the check straight to the result;
// a program request scans each slot in use (table read, then compare), then
// picks a slot and writes it, if one is found, before the result is loaded.
// One request is worked on at a time; the next is taken as soon as the result
// sits in the output register, even while the receiver stalls it.
// Reset marks all slots invalid and restores the config defaults (feature on,
// write-combining on, eight slots, 36 physical bits); no clearing pass.
// depends on mtra_pkg, mtra_ctrl, mtra_datapath, mtra_ram
`timescale 1ns / 1ps

module memory_type_region_allocator #(
  parameter int unsigned MAX_SLOTS = 8
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [mtra_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [mtra_pkg::CFG_W-1:0]        cfg_data_i,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic                              mode_i,
  input  logic [mtra_pkg::ADDR_BITS-1:0]    region_base_i,
  input  logic [mtra_pkg::SIZE_W-1:0]       region_size_i,
  input  logic [mtra_pkg::TYPE_W-1:0]       memory_type_i,
  input  logic [mtra_pkg::SLOT_OUT_W-1:0]   slot_index_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic [mtra_pkg::STATUS_W-1:0]     status_o,
  output logic [mtra_pkg::SLOT_OUT_W-1:0]   chosen_slot_o,
  output logic [mtra_pkg::ADDR_BITS-1:0]    entry_base_o,
  output logic [mtra_pkg::SIZE_W-1:0]       entry_size_o,
  output logic [mtra_pkg::KIND_W-1:0]       entry_type_o,
  output logic                              entry_valid_o
);
  import mtra_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;

  mtra_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  mtra_datapath #(
    .MAX_SLOTS (MAX_SLOTS)
  ) u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .stat_o        (stat),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .mode_i        (mode_i),
    .region_base_i (region_base_i),
    .region_size_i (region_size_i),
    .memory_type_i (memory_type_i),
    .slot_index_i  (slot_index_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .status_o      (status_o),
    .chosen_slot_o (chosen_slot_o),
    .entry_base_o  (entry_base_o),
    .entry_size_o  (entry_size_o),
    .entry_type_o  (entry_type_o),
    .entry_valid_o (entry_valid_o)
  );

endmodule
